>>> rtl/ic_reply_frame_checker_defines.svh
// Assertion macros shared by the reply frame checker RTL.
`ifndef IC_REPLY_FRAME_CHECKER_DEFINES_SVH
`define IC_REPLY_FRAME_CHECKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IC_RFC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ic_reply_frame_checker: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define IC_RFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ic_reply_frame_checker: next-cycle check failed");

`endif

>>> rtl/ic_rfc_pkg.sv
// Types and constants for the reply frame checker.
package ic_rfc_pkg;

    localparam int unsigned POS_W  = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned REG_W  = 16;
    localparam int unsigned IDX_W  = 2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_FRAME_FORMAT     = 2'd0;
    localparam logic [IDX_W-1:0] REG_EXPECTED_LENGTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_EXPECTED_ADDRESS = 2'd2;

    // Frame format codes
    localparam logic FMT_OLD = 1'b0;
    localparam logic FMT_NEW = 1'b1;

    // Field positions relative to the format offset
    localparam logic [POS_W-1:0] LEN_LO_POS  = 16'd2;
    localparam logic [POS_W-1:0] LEN_HI_POS  = 16'd3;
    localparam logic [POS_W-1:0] ADDR_LO_POS = 16'd4;
    localparam logic [POS_W-1:0] ADDR_HI_POS = 16'd5;
    localparam logic [POS_W:0]   BODY_POS    = 17'd6;
    localparam logic [POS_W:0]   MIN_DATA_POS = 17'd7;

    // Old format leaves the first two bytes out of the parity
    localparam logic [POS_W-1:0] OLD_PARITY_START = 16'd2;
    // Parity is only checked from this final-byte position on
    localparam logic [POS_W-1:0] PARITY_CHECK_POS = 16'd2;
    localparam logic [POS_W-1:0] POS_MAX          = 16'hFFFF;

    // Reset values of the configuration registers
    localparam logic             FRAME_FORMAT_RST     = FMT_NEW;
    localparam logic [REG_W-1:0] EXPECTED_LENGTH_RST  = 16'd1;
    localparam logic [REG_W-1:0] EXPECTED_ADDRESS_RST = 16'd0;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              last_byte;
    } in_t;

    typedef struct packed {
        logic              value_valid;
        logic [BYTE_W-1:0] value_byte;
        logic [POS_W-1:0]  value_index;
        logic              frame_end;
        logic              parity_checked;
        logic              parity_ok;
        logic              reply_match;
    } out_t;

    typedef struct packed {
        logic             frame_format;
        logic [REG_W-1:0] expected_length;
        logic [REG_W-1:0] expected_address;
    } cfg_t;

endpackage

>>> rtl/ic_rfc_if.sv
// Valid/ready stream interfaces for frame bytes in and check results out.
interface ic_rfc_in_if
    import ic_rfc_pkg::*;
;
    logic valid;
    logic ready;
    in_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ic_rfc_out_if
    import ic_rfc_pkg::*;
;
    logic valid;
    logic ready;
    out_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/ic_rfc_frame_track.sv
// Per-frame state (position, parity, captured fields) and result logic.
module ic_rfc_frame_track
    import ic_rfc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  in_t  in_data,
    input  cfg_t cfg,
    output out_t result
);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] parity_reg, parity_next;
    logic [REG_W-1:0]  length_reg, length_next;
    logic [REG_W-1:0]  address_reg, address_next;

    logic [POS_W-1:0]  offset;
    logic [POS_W:0]    rel;
    logic              in_body;
    logic              covered;
    logic              match_fields;

    // Format-dependent offsets and body position
    always_comb
    begin
        offset  = (cfg.frame_format == FMT_NEW) ? '0 : POS_W'(1);
        rel     = {1'b0, pos_reg} - ({1'b0, offset} + BODY_POS);
        in_body = !rel[POS_W];
        covered = (cfg.frame_format == FMT_NEW) || (pos_reg >= OLD_PARITY_START);
        match_fields = ({1'b0, pos_reg} >= ({1'b0, offset} + MIN_DATA_POS))
                    && (cfg.expected_length != '0)
                    && (length_reg == cfg.expected_length)
                    && (address_reg == cfg.expected_address);
    end

    // Result for the current byte and next frame state
    always_comb
    begin
        result       = '0;
        pos_next     = pos_reg;
        parity_next  = parity_reg;
        length_next  = length_reg;
        address_next = address_reg;
        if (!in_data.last_byte)
        begin
            if (covered)
            begin
                parity_next = parity_reg ^ in_data.frame_byte;
            end
            if (pos_reg == offset + LEN_LO_POS)
            begin
                length_next[7:0] = in_data.frame_byte;
            end
            else if (pos_reg == offset + LEN_HI_POS)
            begin
                length_next[15:8] = in_data.frame_byte;
            end
            else if (pos_reg == offset + ADDR_LO_POS)
            begin
                address_next[7:0] = in_data.frame_byte;
            end
            else if (pos_reg == offset + ADDR_HI_POS)
            begin
                address_next[15:8] = in_data.frame_byte;
            end
            if ((pos_reg != POS_MAX) && in_body && (rel[POS_W-1:0] < cfg.expected_length))
            begin
                result.value_valid = 1'b1;
                result.value_byte  = in_data.frame_byte;
                result.value_index = rel[POS_W-1:0];
            end
            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
        else
        begin
            result.frame_end      = 1'b1;
            result.parity_checked = (pos_reg >= PARITY_CHECK_POS);
            result.parity_ok      = (pos_reg >= PARITY_CHECK_POS)
                                 && (parity_reg == in_data.frame_byte);
            result.reply_match    = match_fields;
            pos_next     = '0;
            parity_next  = '0;
            length_next  = '0;
            address_next = '0;
        end
    end

    // Frame state registers, advanced once per accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            parity_reg  <= '0;
            length_reg  <= '0;
            address_reg <= '0;
        end
        else if (step)
        begin
            pos_reg     <= pos_next;
            parity_reg  <= parity_next;
            length_reg  <= length_next;
            address_reg <= address_next;
        end
    end

endmodule

>>> rtl/ic_reply_frame_checker.sv
// Reply frame checker: one result per frame byte, parity and reply check at frame end.
// Each result is registered as its byte is accepted.
// Throughput: one byte per cycle while results are taken; the output register is refilled in the cycle it drains.
// Only an untaken result stalls input (ready = output empty or taken).
// Reset: frame state clears, output empty, frame_format=1, expected_length=1, address=0.
// Frame state also clears after every final byte.
`include "ic_reply_frame_checker_defines.svh"

module ic_reply_frame_checker
    import ic_rfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    ic_rfc_in_if.sink            in_ch,
    ic_rfc_out_if.source         out_ch
);

    cfg_t cfg_reg;
    out_t result;
    out_t out_reg;
    logic out_valid_reg;
    logic in_fire;

    // Output register frees up when empty or being taken
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_format     <= FRAME_FORMAT_RST;
            cfg_reg.expected_length  <= EXPECTED_LENGTH_RST;
            cfg_reg.expected_address <= EXPECTED_ADDRESS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_FORMAT:     cfg_reg.frame_format     <= cfg_data[0];
                REG_EXPECTED_LENGTH:  cfg_reg.expected_length  <= cfg_data;
                REG_EXPECTED_ADDRESS: cfg_reg.expected_address <= cfg_data;
                default:              ;
            endcase
        end
    end

    ic_rfc_frame_track u_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (in_fire),
        .in_data (in_ch.payload),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            out_valid_reg <= in_ch.valid;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_reg <= result;
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_reg;

    // Checks
    `IC_RFC_ASSERT_NEXT(a_last_gives_end, clk, rst_n, in_fire && in_ch.payload.last_byte, out_ch.valid && out_ch.payload.frame_end)
    `IC_RFC_ASSERT_SAME(a_no_value_at_end, clk, rst_n, out_ch.valid && out_ch.payload.frame_end, !out_ch.payload.value_valid)
    `IC_RFC_ASSERT_SAME(a_ok_needs_check, clk, rst_n, out_ch.valid && out_ch.payload.parity_ok, out_ch.payload.parity_checked && out_ch.payload.frame_end)

endmodule
